[sv/itpc_pkg.sv]
// ----------------------------------------------------------------------------
// itpc_pkg
// Token kinds, error codes, queue words and the precedence rule used by
// the front and back parts of the infix to postfix converter.
// ----------------------------------------------------------------------------
package itpc_pkg;

  typedef enum logic [2:0] {
    KIND_VALUE,
    KIND_VARIABLE,
    KIND_LBR,
    KIND_RBR,
    KIND_UNARY,
    KIND_BINARY,
    KIND_COMMA,
    KIND_FUNC
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_OVERFLOW,
    ERR_UNMATCHED,
    ERR_COMMA
  } err_t;

  typedef enum logic [2:0] {
    ST_WORK,
    ST_DROP,
    ST_FLUSH,
    ST_END,
    ST_FINISH
  } state_t;

  typedef logic [7:0] count_t;

  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_MUL    = 8'd42;
  localparam logic [7:0] CH_DIV    = 8'd47;
  localparam count_t     COUNT_MAX = 8'd255;

  // classified token word, payload travels beside it
  typedef struct packed {
    kind_t kind;
    logic  addsub;
    logic  muldiv;
    logic  last;
  } tok_t;

  // operator stack entry tag
  typedef struct packed {
    kind_t kind;
    logic  addsub;
  } tag_t;

  // result word, payload travels beside it
  typedef struct packed {
    logic  valid;
    kind_t kind;
    err_t  err;
    logic  run_last;
    logic  done;
  } res_t;

  function automatic logic ranks_below(kind_t lk, logic l_addsub, kind_t rk,
                                       logic r_muldiv);
    logic r;
    if (rk == KIND_UNARY) r = 1'b1;
    else if (lk == KIND_UNARY) r = 1'b0;
    else if (rk == KIND_LBR) r = 1'b0;
    else if (lk == KIND_LBR) r = 1'b1;
    else if (rk == KIND_COMMA) r = 1'b0;
    else if (lk == KIND_COMMA) r = 1'b1;
    else if (lk == KIND_BINARY && rk == KIND_FUNC) r = 1'b1;
    else if (lk == KIND_BINARY && rk == KIND_BINARY) r = l_addsub && r_muldiv;
    else r = 1'b0;
    return r;
  endfunction

endpackage

[sv/infix_to_postfix_converter_top.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter: infix tokens in, postfix tokens out.
// ----------------------------------------------------------------------------
// Input side is a queue: drive a word and push; it is taken on a clock edge
// with push high and full low. Result side is a queue too: the oldest word
// sits on the out_ ports while empty is low and leaves on an edge with pop
// high. A four word queue parts the classifier from the stack engine, and a
// four word queue holds finished results, so either side may stall alone.
// In the stack engine a token pops operators one at a time, emitting each,
// and after every stack change the engine waits while the registered stack
// RAM read settles. An end of expression pops each operator left, then
// emits the end marker. Each word waits in a one word hold until the
// engine's next word or the end of its token.
// When pop stays low the result queue fills, the engine holds, and full
// rises once the input queue is full as well; nothing is lost.
// Reset (synchronous, rst_n low) empties both queues and both stacks and
// clears error skipping; no clearing pass is needed.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH  = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [2:0]              in_token_kind,
  input  logic [PAYLOAD_BITS-1:0] in_token_payload,
  input  logic                    in_end_of_expression,
  output logic                    empty,
  input  logic                    pop,
  output logic                    out_valid,
  output logic [2:0]              out_kind,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic [1:0]              out_error_code,
  output logic                    out_run_last,
  output logic                    out_expression_done
);

  import itpc_pkg::*;

  localparam int TW = $bits(tok_t) + PAYLOAD_BITS;
  localparam int RW = $bits(res_t) + PAYLOAD_BITS;

  logic                    f_push, f_full;
  tok_t                    f_tok;
  logic [PAYLOAD_BITS-1:0] f_pay;
  logic [TW-1:0]           q_rdata;
  logic                    q_empty, q_pop;
  tok_t                    q_tok;
  logic [PAYLOAD_BITS-1:0] q_pay;
  logic                    o_push, o_full;
  res_t                    o_res, r_res;
  logic [PAYLOAD_BITS-1:0] o_pay, r_pay;
  logic [RW-1:0]           r_rdata;

  itpc_front #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
    .in_push    (push),
    .in_kind    (in_token_kind),
    .in_payload (in_token_payload),
    .in_last    (in_end_of_expression),
    .in_full    (full),
    .q_push     (f_push),
    .q_tok      (f_tok),
    .q_payload  (f_pay),
    .q_full     (f_full)
  );

  itpc_fifo #(.WIDTH(TW), .DEPTH(4)) u_tok_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata ({f_tok, f_pay}),
    .full  (f_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_tok = tok_t'(q_rdata[PAYLOAD_BITS +: $bits(tok_t)]);
  assign q_pay = q_rdata[PAYLOAD_BITS-1:0];

  itpc_back #(.STACK_DEPTH(STACK_DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_tok     (q_tok),
    .q_payload (q_pay),
    .q_pop     (q_pop),
    .o_full    (o_full),
    .o_push    (o_push),
    .o_res     (o_res),
    .o_payload (o_pay)
  );

  itpc_fifo #(.WIDTH(RW), .DEPTH(4)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .wdata ({o_res, o_pay}),
    .full  (o_full),
    .pop   (pop),
    .rdata (r_rdata),
    .empty (empty)
  );

  assign r_res = res_t'(r_rdata[PAYLOAD_BITS +: $bits(res_t)]);
  assign r_pay = r_rdata[PAYLOAD_BITS-1:0];

  assign out_valid           = r_res.valid;
  assign out_kind            = r_res.kind;
  assign out_payload         = r_pay;
  assign out_error_code      = r_res.err;
  assign out_run_last        = r_res.run_last;
  assign out_expression_done = r_res.done;

endmodule

[sv/itpc_ram.sv]
// ----------------------------------------------------------------------------
// itpc_ram
// Simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module itpc_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 32,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[sv/itpc_fifo.sv]
// ----------------------------------------------------------------------------
// itpc_fifo
// Small register FIFO with full and empty flags.
// ----------------------------------------------------------------------------
module itpc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[sv/itpc_front.sv]
// ----------------------------------------------------------------------------
// itpc_front
// Accepts input words and classifies them for the back part's queue.
// ----------------------------------------------------------------------------
module itpc_front #(
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    in_push,
  input  logic [2:0]              in_kind,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  input  logic                    in_last,
  output logic                    in_full,
  output logic                    q_push,
  output itpc_pkg::tok_t          q_tok,
  output logic [PAYLOAD_BITS-1:0] q_payload,
  input  logic                    q_full
);

  import itpc_pkg::*;

  assign in_full   = q_full;
  assign q_push    = in_push && !q_full;
  assign q_payload = in_payload;

  always_comb begin
    q_tok.kind   = kind_t'(in_kind);
    q_tok.addsub = (in_payload == PAYLOAD_BITS'(CH_PLUS)) ||
                   (in_payload == PAYLOAD_BITS'(CH_MINUS));
    q_tok.muldiv = (in_payload == PAYLOAD_BITS'(CH_MUL)) ||
                   (in_payload == PAYLOAD_BITS'(CH_DIV));
    q_tok.last   = in_last;
  end

endmodule

[sv/itpc_back.sv]
// ----------------------------------------------------------------------------
// itpc_back
// Runs the operator and argument count stacks and emits result words.
// ----------------------------------------------------------------------------
module itpc_back #(
  parameter int STACK_DEPTH  = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  itpc_pkg::tok_t          q_tok,
  input  logic [PAYLOAD_BITS-1:0] q_payload,
  output logic                    q_pop,
  input  logic                    o_full,
  output logic                    o_push,
  output itpc_pkg::res_t          o_res,
  output logic [PAYLOAD_BITS-1:0] o_payload
);

  import itpc_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int EW = $bits(tag_t) + PAYLOAD_BITS;

  state_t                  state_r, state_nxt;
  logic [DW-1:0]           d_r, d_nxt;
  logic [DW-1:0]           fd_r, fd_nxt;
  tag_t                    top_tag_r, top_tag_nxt;
  logic [PAYLOAD_BITS-1:0] top_pay_r, top_pay_nxt;
  count_t                  cnt_top_r, cnt_top_nxt;
  logic                    skip_r, skip_nxt;
  logic                    stale_r, stale_nxt;
  logic                    last_r, last_nxt;
  logic                    hold_v_r, hold_v_nxt;
  res_t                    hold_res_r, hold_res_nxt;
  logic [PAYLOAD_BITS-1:0] hold_pay_r, hold_pay_nxt;

  logic [EW-1:0]           op_rdata;
  count_t                  cnt_rdata;
  tag_t                    below_tag;
  logic [PAYLOAD_BITS-1:0] below_pay;
  logic [DW-1:0]           d_m1, d_m2, fd_m1, fd_m2;

  logic run, active, full_op, full_cnt, below_func;
  logic tok_fin;
  err_t tok_err;
  count_t cnt_cur, cnt_plus;

  logic                    emit;
  res_t                    em_res;
  logic [PAYLOAD_BITS-1:0] em_pay;
  logic op_push, op_pop, cnt_push, cnt_pop, cnt_inc, clr;
  logic skip_set, skip_clr, fin_push;

  assign d_m1  = d_r - DW'(1);
  assign d_m2  = d_r - DW'(2);
  assign fd_m1 = fd_r - DW'(1);
  assign fd_m2 = fd_r - DW'(2);

  itpc_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_op_ram (
    .clk   (clk),
    .we    (op_push && (d_r != '0)),
    .waddr (d_m1[AW-1:0]),
    .wdata ({top_tag_r, top_pay_r}),
    .raddr (d_m2[AW-1:0]),
    .rdata (op_rdata)
  );

  itpc_ram #(.WIDTH($bits(count_t)), .DEPTH(STACK_DEPTH)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_push && (fd_r != '0)),
    .waddr (fd_m1[AW-1:0]),
    .wdata (cnt_top_r),
    .raddr (fd_m2[AW-1:0]),
    .rdata (cnt_rdata)
  );

  assign below_tag = tag_t'(op_rdata[PAYLOAD_BITS +: $bits(tag_t)]);
  assign below_pay = op_rdata[PAYLOAD_BITS-1:0];

  assign run        = !stale_r && !(hold_v_r && o_full);
  assign active     = (state_r == ST_WORK) && !q_empty && run;
  assign full_op    = (d_r == DW'(STACK_DEPTH));
  assign full_cnt   = (fd_r == DW'(STACK_DEPTH));
  assign below_func = (d_r > DW'(1)) && (below_tag.kind == KIND_FUNC);
  assign cnt_cur    = (fd_r != '0) ? cnt_top_r : '0;
  assign cnt_plus   = (cnt_cur == COUNT_MAX) ? COUNT_MAX : cnt_cur + 8'd1;

  // classify the head word against the stack top
  always_comb begin
    tok_fin = 1'b1;
    tok_err = ERR_NONE;
    case (q_tok.kind)
      KIND_LBR, KIND_UNARY: begin
        if (full_op) tok_err = ERR_OVERFLOW;
      end
      KIND_BINARY: begin
        if ((d_r != '0) &&
            !ranks_below(top_tag_r.kind, top_tag_r.addsub, KIND_BINARY, q_tok.muldiv)) begin
          tok_fin = 1'b0;
        end else if (full_op) begin
          tok_err = ERR_OVERFLOW;
        end
      end
      KIND_COMMA: begin
        if (fd_r == '0) begin
          tok_err = ERR_COMMA;
        end else if ((d_r != '0) &&
                     !ranks_below(top_tag_r.kind, top_tag_r.addsub, KIND_COMMA, 1'b0)) begin
          tok_fin = 1'b0;
        end
      end
      KIND_FUNC: begin
        if (full_op || full_cnt) tok_err = ERR_OVERFLOW;
      end
      KIND_RBR: begin
        if ((d_r != '0) && (top_tag_r.kind != KIND_LBR)) tok_fin = 1'b0;
        else if (d_r == '0) tok_err = ERR_UNMATCHED;
      end
      default: begin
        tok_fin = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_WORK: begin
        if (active) begin
          if (skip_r) begin
            state_nxt = q_tok.last ? ST_FINISH : ST_WORK;
          end else if (tok_fin) begin
            if (tok_err != ERR_NONE) state_nxt = q_tok.last ? ST_END : ST_FINISH;
            else if (q_tok.kind == KIND_RBR && below_func) state_nxt = ST_DROP;
            else state_nxt = q_tok.last ? ST_FLUSH : ST_FINISH;
          end
        end
      end
      ST_DROP: begin
        if (run) state_nxt = last_r ? ST_FLUSH : ST_FINISH;
      end
      ST_FLUSH: begin
        if (run && d_r == '0) state_nxt = ST_END;
      end
      ST_END: begin
        if (run) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!hold_v_r || !o_full) state_nxt = ST_WORK;
      end
      default: begin
        state_nxt = ST_WORK;
      end
    endcase
  end

  always_comb begin
    emit     = 1'b0;
    em_res   = '0;
    em_pay   = '0;
    op_push  = 1'b0;
    op_pop   = 1'b0;
    cnt_push = 1'b0;
    cnt_pop  = 1'b0;
    cnt_inc  = 1'b0;
    clr      = 1'b0;
    q_pop    = 1'b0;
    skip_set = 1'b0;
    skip_clr = 1'b0;
    fin_push = 1'b0;
    case (state_r)
      ST_WORK: begin
        if (active) begin
          if (skip_r) begin
            q_pop = 1'b1;
            if (q_tok.last) begin
              emit        = 1'b1;
              em_res.done = 1'b1;
              skip_clr    = 1'b1;
            end
          end else if (tok_fin) begin
            q_pop = 1'b1;
            if (tok_err != ERR_NONE) begin
              emit       = 1'b1;
              em_res.err = tok_err;
              clr        = 1'b1;
              skip_set   = !q_tok.last;
            end else begin
              case (q_tok.kind)
                KIND_VALUE, KIND_VARIABLE: begin
                  emit         = 1'b1;
                  em_res.valid = 1'b1;
                  em_res.kind  = q_tok.kind;
                  em_pay       = q_payload;
                end
                KIND_LBR, KIND_UNARY, KIND_BINARY: begin
                  op_push = 1'b1;
                end
                KIND_COMMA: begin
                  cnt_inc = 1'b1;
                end
                KIND_FUNC: begin
                  op_push  = 1'b1;
                  cnt_push = 1'b1;
                end
                KIND_RBR: begin
                  op_pop = 1'b1;
                  if (below_func) begin
                    emit         = 1'b1;
                    em_res.valid = 1'b1;
                    em_res.kind  = KIND_FUNC;
                    em_pay       = PAYLOAD_BITS'(cnt_plus);
                    cnt_pop      = (fd_r != '0);
                  end
                end
                default: begin
                  op_push = 1'b0;
                end
              endcase
            end
          end else begin
            emit         = 1'b1;
            em_res.valid = 1'b1;
            em_res.kind  = top_tag_r.kind;
            em_pay       = top_pay_r;
            op_pop       = 1'b1;
          end
        end
      end
      ST_DROP: begin
        op_pop = run;
      end
      ST_FLUSH: begin
        if (run && d_r != '0) begin
          emit         = 1'b1;
          em_res.valid = 1'b1;
          em_res.kind  = top_tag_r.kind;
          em_pay       = top_pay_r;
          op_pop       = 1'b1;
        end
      end
      ST_END: begin
        if (run) begin
          emit        = 1'b1;
          em_res.done = 1'b1;
          clr         = 1'b1;
        end
      end
      ST_FINISH: begin
        fin_push = hold_v_r && !o_full;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    o_push             = (emit && hold_v_r) || fin_push;
    o_res              = hold_res_r;
    o_res.run_last     = fin_push;
    o_payload          = hold_pay_r;
  end

  always_comb begin
    d_nxt        = d_r;
    fd_nxt       = fd_r;
    top_tag_nxt  = top_tag_r;
    top_pay_nxt  = top_pay_r;
    cnt_top_nxt  = cnt_top_r;
    skip_nxt     = skip_r;
    last_nxt     = last_r;
    hold_v_nxt   = hold_v_r;
    hold_res_nxt = hold_res_r;
    hold_pay_nxt = hold_pay_r;
    stale_nxt    = op_push || op_pop || cnt_push || cnt_pop || clr;
    if (q_pop) last_nxt = q_tok.last;
    if (skip_set) skip_nxt = 1'b1;
    else if (skip_clr) skip_nxt = 1'b0;
    if (emit) begin
      hold_v_nxt   = 1'b1;
      hold_res_nxt = em_res;
      hold_pay_nxt = em_pay;
    end else if (fin_push) begin
      hold_v_nxt = 1'b0;
    end
    if (clr) begin
      d_nxt  = '0;
      fd_nxt = '0;
    end else begin
      if (op_push) begin
        d_nxt       = d_r + DW'(1);
        top_tag_nxt = '{kind: q_tok.kind, addsub: q_tok.addsub};
        top_pay_nxt = q_payload;
      end else if (op_pop) begin
        d_nxt       = d_m1;
        top_tag_nxt = below_tag;
        top_pay_nxt = below_pay;
      end
      if (cnt_push) begin
        fd_nxt      = fd_r + DW'(1);
        cnt_top_nxt = '0;
      end else if (cnt_pop) begin
        fd_nxt      = fd_m1;
        cnt_top_nxt = cnt_rdata;
      end else if (cnt_inc) begin
        cnt_top_nxt = (cnt_top_r == COUNT_MAX) ? COUNT_MAX : cnt_top_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_WORK;
      d_r      <= '0;
      fd_r     <= '0;
      skip_r   <= 1'b0;
      stale_r  <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      d_r      <= d_nxt;
      fd_r     <= fd_nxt;
      skip_r   <= skip_nxt;
      stale_r  <= stale_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_tag_r  <= top_tag_nxt;
    top_pay_r  <= top_pay_nxt;
    cnt_top_r  <= cnt_top_nxt;
    last_r     <= last_nxt;
    hold_res_r <= hold_res_nxt;
    hold_pay_r <= hold_pay_nxt;
  end

endmodule
